// ===== rtl/tsc_pkg.sv =====
`timescale 1ns / 1ps
package tsc_pkg;
   localparam int MemHalfwords = 32768;
   localparam int MemAw = $clog2(MemHalfwords);
   localparam logic [15:0] StartPcReset = 16'h0034;
   localparam logic [1:0] KIND_FETCH = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   // one input item as held in the queue
   typedef struct packed {
      logic        mode;
      logic [14:0] load_index;
      logic [15:0] load_value;
   } item_type;

   function automatic logic [MemAw-1:0] mem_slot(input logic [15:0] a);
      mem_slot = a[MemAw:1];
   endfunction
endpackage

// ===== rtl/tsc_front.sv =====
`timescale 1ns / 1ps
module tsc_front import tsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   output logic        q_valid,
   input  logic        q_ready,
   output item_type    q_item
);
   // two-entry queue between front and back
   item_type   buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic       push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign q_valid  = cnt_ff != 2'd0;
   assign q_item   = buf_ff[rd_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;
   assign cnt_in   = cnt_ff + {1'b0, push} - {1'b0, pop};
   assign rd_in    = rd_ff ^ pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
      if (push) buf_ff[rd_ff ^ cnt_ff[0]] <= in_item;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready) else $error("push while full");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> cnt_ff <= 2'd2) else $error("pop broke count");
endmodule

// ===== rtl/tsc_back.sv =====
`timescale 1ns / 1ps
module tsc_back import tsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cfg_we,
   input  logic [15:0] cfg_data,
   input  logic        q_valid,
   output logic        q_ready,
   input  item_type    q_item,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [1:0]  out_kind,
   output logic [15:0] out_addr,
   output logic        out_last,
   output logic        out_halt
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC  = 3'd1;
   localparam logic [2:0] S_MEM  = 3'd2;
   localparam logic [2:0] S_DATA = 3'd3;
   localparam logic [2:0] S_OUT2 = 3'd4;

   logic [2:0]  st_ff, st_in;
   logic [15:0] rf_ff [8];
   logic [15:0] pc_ff, sp_ff;
   logic        n_ff, z_ff, stop_ff;
   logic [15:0] mem [MemHalfwords];
   logic [15:0] rdata_ff, ir;
   logic [15:0] addr_ff;
   logic [1:0]  kind_ff;
   logic [2:0]  md_ff;
   // output register
   logic        ov_ff;
   logic [1:0]  ok_ff;
   logic [15:0] oa_ff;
   logic        ol_ff, oh_ff;

   assign out_valid = ov_ff;
   assign out_kind  = ok_ff;
   assign out_addr  = oa_ff;
   assign out_last  = ol_ff;
   assign out_halt  = oh_ff;
   assign ir        = rdata_ff;
   wire out_free    = !ov_ff || out_ready;
   assign q_ready   = st_ff == S_IDLE && (!q_item.mode || (stop_ff || out_free));
   wire take        = q_valid && q_ready;

   // decode fields
   logic [2:0]  rs, rd, rh;
   logic [4:0]  imm5;
   logic [7:0]  imm8;
   logic [15:0] vs, vo, vh, v, nxt, a, off, sub;
   logic [1:0]  kd;
   logic [2:0]  wr;
   logic        we, sf, stp;
   logic [15:0] wv, spn;
   always_comb begin
      rs = ir[5:3]; rd = ir[2:0]; rh = ir[10:8];
      imm5 = ir[10:6]; imm8 = ir[7:0];
      vs = rf_ff[rs]; vo = rf_ff[imm5[2:0]]; vh = rf_ff[rh];
      nxt = pc_ff + 16'd2; a = 16'd0; kd = KIND_FETCH;
      wr = rd; we = 1'b0; wv = 16'd0; sf = 1'b0; sub = 16'd0;
      spn = sp_ff; stp = 1'b0; off = 16'd0; v = 16'd0;
      unique case (ir[15:12])
         4'h0: begin
            we = 1'b1;
            if (imm5[4]) wv = 16'd0;
            else if (ir[11]) wv = vs >> imm5[3:0];
            else wv = vs << imm5[3:0];
         end
         4'h1: if (ir[11:9] == 3'b100) begin we = 1'b1; wv = vs + vo; end
         4'h2: if (ir[11]) begin sf = 1'b1; sub = vh - {8'd0, imm8}; end
               else begin we = 1'b1; wr = rh; wv = {8'd0, imm8}; end
         4'h3: if (!ir[11]) begin we = 1'b1; wr = rh; wv = vh + {8'd0, imm8}; end
         4'h4: if (ir[11]) begin
                  a = pc_ff + 16'd4 + {6'd0, imm8, 2'b00}; kd = KIND_READ; wr = rh;
               end else if (ir[11:6] == 6'b011010) begin we = 1'b1; wv = vs; end
         4'h5: if (ir[11:9] == 3'b101) begin a = vs + vo; kd = KIND_READ; end
         4'h6: begin a = vs + {9'd0, imm5, 2'b00}; kd = ir[11] ? KIND_READ : KIND_WRITE; end
         4'h8: begin a = vs + {10'd0, imm5, 1'b0}; kd = ir[11] ? KIND_READ : KIND_WRITE; end
         4'hA: if (ir[11]) begin we = 1'b1; wr = rh; wv = sp_ff + {6'd0, imm8, 2'b00}; end
         4'hB: if ((ir & 16'h0D00) == 16'd0) begin
                  off = {7'd0, ir[6:0], 2'b00};
                  if (ir[7]) begin v = sp_ff - off; sf = 1'b1; sub = v; end
                  else v = sp_ff + off;
                  spn = v;
               end else if ((ir & 16'h0D00) == 16'h0D00) stp = 1'b1;
         4'hD: if (ir[11:8] == 4'hD && (n_ff || z_ff))
                  nxt = pc_ff + 16'd4 + {{7{imm8[7]}}, imm8, 1'b0};
         4'hE: nxt = pc_ff + 16'd4 + {{4{ir[11]}}, ir[10:0], 1'b0};
         default: ;
      endcase
   end

   // sequencer: fetch, decode/execute, optional data access
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (take && q_item.mode && !stop_ff) st_in = S_MEM;
         S_MEM:  st_in = S_DEC;
         S_DEC:  st_in = (kd == KIND_FETCH) ? S_IDLE : S_DATA;
         S_DATA: st_in = S_OUT2;
         S_OUT2: if (out_free) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      // memory port
      if (st_ff == S_IDLE && take && !q_item.mode)
         mem[q_item.load_index[MemAw-1:0]] <= q_item.load_value;
      else if (st_ff == S_DATA && kind_ff == KIND_WRITE)
         mem[mem_slot(addr_ff)] <= rf_ff[md_ff];
      if (st_ff == S_IDLE) rdata_ff <= mem[mem_slot(pc_ff)];
      else if (st_ff == S_DATA) rdata_ff <= mem[mem_slot(addr_ff)];
      if (st_ff == S_DEC) begin addr_ff <= a; kind_ff <= kd; md_ff <= wr; end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; pc_ff <= StartPcReset; sp_ff <= 16'd0;
         n_ff <= 1'b0; z_ff <= 1'b0; stop_ff <= 1'b0; ov_ff <= 1'b0;
         for (int i = 0; i < 8; i++) rf_ff[i] <= 16'd0;
      end else begin
         st_ff <= st_in;
         // output valid: set by a new trace, cleared when taken
         if (st_ff == S_DEC || (st_ff == S_OUT2 && out_free)) ov_ff <= 1'b1;
         else if (ov_ff && out_ready) ov_ff <= 1'b0;
         if (st_ff == S_DEC) begin
            if (we) rf_ff[wr] <= wv;
            if (sf) begin n_ff <= sub[15]; z_ff <= sub == 16'd0; end
            sp_ff <= spn; pc_ff <= nxt;
            if (stp) stop_ff <= 1'b1;
            ok_ff <= KIND_FETCH; oa_ff <= pc_ff;
            ol_ff <= kd == KIND_FETCH; oh_ff <= stop_ff | stp;
         end else if (cfg_we) pc_ff <= cfg_data;
         if (st_ff == S_OUT2 && out_free) begin
            if (kind_ff == KIND_READ) rf_ff[md_ff] <= rdata_ff;
            ok_ff <= kind_ff; oa_ff <= addr_ff;
            ol_ff <= 1'b1; oh_ff <= stop_ff;
         end
      end
   end

   a_last: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_OUT2 && out_free |=> out_valid && out_last)
      else $error("data trace not last");
   a_dec: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_DEC |=> out_valid && out_kind == KIND_FETCH)
      else $error("fetch trace missing");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IDLE |-> !q_ready) else $error("accepted while busy");
endmodule

// ===== rtl/thumb_subset_core_step.sv =====
`timescale 1ns / 1ps
// Small 16-bit Thumb subset core driven by items.
// req_ channel: tuser is the mode, 0 writes a program memory halfword, 1 runs
// one instruction. rsp_ channel: trace items, a fetch trace then an optional
// data trace, the last one flagged with tlast. csr_ channel loads start_pc
// into the program counter; write it only while idle.
// A two-entry queue holds requests; the back end takes the item and reads pc
// from the program memory as it takes it, waits in S_MEM, decodes and executes
// in S_DEC and, for loads and stores, does the data access in S_DATA and S_OUT2.
// A load item is written to memory as it is taken, and the back end stays idle.
// The fetch trace is registered in S_DEC, which follows S_MEM.
// Reset clears registers, flags, queue and sets pc to 52; memory is not
// cleared. When rsp_tready is low the trace is held and the core waits;
// requests keep queuing until the queue is full.
// A POP with pc (bits 11, 10 and 8 set) halts the core; later execute items are taken and dropped.
module thumb_subset_core_step import tsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // load_index[14:0], load_value[15:0], zero
   input  logic        req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // access_address[15:0]
   output logic        rsp_tlast,
   output logic [2:0]  rsp_tuser,  // access_kind[1:0], halted_flag
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   item_type   in_item, q_item;
   logic       q_valid, q_ready;
   logic [1:0] kind;
   logic       halt;

   assign in_item.mode       = req_tuser;
   assign in_item.load_index = req_tdata[14:0];
   assign in_item.load_value = req_tdata[30:15];
   assign csr_ready = 1'b1;
   assign rsp_tuser = {halt, kind};

   tsc_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item, .q_valid, .q_ready, .q_item
   );
   tsc_back u_back (
      .clock, .reset, .cfg_we(csr_valid), .cfg_data(csr_data),
      .q_valid, .q_ready, .q_item, .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_kind(kind), .out_addr(rsp_tdata), .out_last(rsp_tlast), .out_halt(halt)
   );
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import tsc_pkg::*;

   localparam int WatchLimit = 5000;
   localparam int IdleWait = 20;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic        last;
      logic        halt;
   } trace_type;

   // reference behavior of the core plus the queue of traces still owed
   class trace_board;
      logic [15:0] regs[8];
      logic [15:0] pc, sp;
      bit          neg, zer, halted;
      logic [15:0] mem[MemHalfwords];
      bit          written[MemHalfwords];
      trace_type   owed[$];
      int          execs, loads;

      function void reset_state();
         foreach (regs[i]) regs[i] = '0;
         pc = StartPcReset;
         sp = '0;
         neg = 0;
         zer = 0;
         halted = 0;
      endfunction

      function void set_start(logic [15:0] v);
         pc = v;
      endfunction

      function void set_flags(logic [15:0] v);
         neg = v[15];
         zer = (v == 16'h0000);
      endfunction

      // data access an instruction makes from the present state
      function void access_of(input logic [15:0] ir, input logic [15:0] at,
                              output logic [1:0] kind, output logic [15:0] addr,
                              output logic [2:0] dst);
         kind = KIND_FETCH;
         addr = '0;
         dst = ir[2:0];
         case (ir[15:12])
            4'h4: if (ir[11]) begin
               addr = at + 16'd4 + {6'd0, ir[7:0], 2'b00};
               kind = KIND_READ;
               dst = ir[10:8];
            end
            4'h5: if (ir[11:9] == 3'b101) begin
               addr = regs[ir[5:3]] + regs[ir[8:6]];
               kind = KIND_READ;
            end
            4'h6: begin
               addr = regs[ir[5:3]] + {9'd0, ir[10:6], 2'b00};
               kind = ir[11] ? KIND_READ : KIND_WRITE;
            end
            4'h8: begin
               addr = regs[ir[5:3]] + {10'd0, ir[10:6], 1'b0};
               kind = ir[11] ? KIND_READ : KIND_WRITE;
            end
            default: ;
         endcase
      endfunction

      function void note(item_type it);
         logic [15:0] ir, nxt, v, addr, off, pc0;
         logic [1:0]  kind;
         logic [2:0]  rs, rd, rh, dst;
         logic [4:0]  imm5;
         logic [7:0]  imm8;
         if (!it.mode) begin
            mem[it.load_index] = it.load_value;
            written[it.load_index] = 1;
            loads++;
            return;
         end
         if (halted) return;
         execs++;
         pc0 = pc;
         ir = mem[pc0[15:1]];
         nxt = pc0 + 16'd2;
         rs = ir[5:3];
         rd = ir[2:0];
         rh = ir[10:8];
         imm5 = ir[10:6];
         imm8 = ir[7:0];
         access_of(ir, pc0, kind, addr, dst);
         case (ir[15:12])
            4'h0: begin
               v = regs[rs];
               if (imm5 >= 5'd16) v = '0;
               else if (ir[11]) v = v >> imm5;
               else v = v << imm5;
               regs[rd] = v;
            end
            4'h1: if (ir[11:9] == 3'b100) regs[rd] = regs[rs] + regs[imm5[2:0]];
            4'h2: begin
               if (ir[11]) set_flags(regs[rh] - {8'd0, imm8});
               else regs[rh] = {8'd0, imm8};
            end
            4'h3: if (!ir[11]) regs[rh] = regs[rh] + {8'd0, imm8};
            4'h4: if (!ir[11] && ir[11:6] == 6'b011010) regs[rd] = regs[rs];
            4'hA: if (ir[11]) regs[rh] = sp + {6'd0, imm8, 2'b00};
            4'hB: begin
               if ({ir[11:10], ir[8]} == 3'b000) begin
                  off = {7'd0, ir[6:0], 2'b00};
                  if (ir[7]) begin
                     sp = sp - off;
                     set_flags(sp);
                  end else begin
                     sp = sp + off;
                  end
               end else if ({ir[11:10], ir[8]} == 3'b111) begin
                  halted = 1;
               end
            end
            4'hD: if (ir[11:8] == 4'hD && (neg || zer))
               nxt = pc0 + 16'd4 + {{7{imm8[7]}}, imm8, 1'b0};
            4'hE: nxt = pc0 + 16'd4 + {{4{ir[11]}}, ir[10:0], 1'b0};
            default: ;
         endcase
         if (kind == KIND_READ) begin
            regs[dst] = mem[addr[15:1]];
         end else if (kind == KIND_WRITE) begin
            mem[addr[15:1]] = regs[dst];
            written[addr[15:1]] = 1;
         end
         pc = nxt;
         owed.push_back('{KIND_FETCH, pc0, kind == KIND_FETCH, halted});
         if (kind != KIND_FETCH) owed.push_back('{kind, addr, 1'b1, halted});
      endfunction

      function bit check(trace_type got, output string why);
         trace_type want;
         why = "";
         if (owed.size() == 0) begin
            $sformat(why, "unexpected trace kind %0d addr %h", got.kind, got.addr);
            return 0;
         end
         want = owed.pop_front();
         if (got.kind != want.kind) $sformat(why, "%s kind %0d/%0d", why, got.kind, want.kind);
         if (got.addr != want.addr) $sformat(why, "%s addr %h/%h", why, got.addr, want.addr);
         if (got.last != want.last) $sformat(why, "%s last %b/%b", why, got.last, want.last);
         if (got.halt != want.halt) $sformat(why, "%s halt %b/%b", why, got.halt, want.halt);
         return why == "";
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // load_index[14:0], load_value[15:0], zero
   logic        req_tuser = 0;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;       // access_address[15:0]
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;       // access_kind[1:0], halted_flag
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   trace_board board;
   int errors = 0;
   int items_sent = 0;
   int traces_seen = 0;
   int quiet = 0;
   int stall = 0;

   thumb_subset_core_step u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   task automatic report(string why);
      errors++;
      $display("mismatch at %0t:%s", $time, why);
   endtask

   // random gap, mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   task automatic send_item(item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {1'b0, it.load_value, it.load_index};
      req_tuser <= it.mode;
      do @(posedge clock); while (!req_tready);
      board.note(it);
      items_sent++;
   endtask

   task automatic send_load(logic [14:0] idx, logic [15:0] val);
      send_item('{1'b0, idx, val});
   endtask

   // place the instruction at pc, back any read with written data, then run it
   task automatic run_instr(logic [15:0] ir);
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [2:0]  dst;
      send_load(board.pc[15:1], ir);
      board.access_of(ir, board.pc, kind, addr, dst);
      if (kind == KIND_READ && !board.written[addr[15:1]])
         send_load(addr[15:1], 16'($urandom));
      send_item('{1'b1, 15'($urandom), 16'($urandom)});
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (IdleWait) @(posedge clock);
   endtask

   task automatic write_start(logic [15:0] v);
      drain();
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      board.set_start(v);
   endtask

   // mostly well-formed instructions with random operands, some raw words
   function automatic logic [15:0] rand_instr();
      logic [15:0] w;
      w = 16'($urandom);
      if ($urandom_range(0, 99) < 80) begin
         case ($urandom_range(0, 12))
            0: w[15:12] = 4'h0;
            1: w[15:9] = 7'b0001100;
            2: w[15:12] = 4'h2;
            3: w[15:11] = 5'b00110;
            4: w[15:11] = 5'b01001;
            5: w[15:6] = 10'b0100011010;
            6: w[15:9] = 7'b0101101;
            7: w[15:12] = 4'h6;
            8: w[15:12] = 4'h8;
            9: w[15:11] = 5'b10101;
            10: w[15:8] = 8'hB0;
            11: w[15:8] = 8'hDD;
            default: w[15:12] = 4'hE;
         endcase
      end
      // keep the core running until the planned halt
      if (w[15:12] == 4'hB && {w[11:10], w[8]} == 3'b111) w[10] = 0;
      return w;
   endfunction

   task automatic random_until(int target);
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0)
            send_load(15'($urandom), 16'($urandom));
         else
            run_instr(rand_instr());
      end
   endtask

   // check traces, random back pressure
   always @(posedge clock) begin
      string why;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            traces_seen++;
            if (!board.check('{rsp_tuser[1:0], rsp_tdata, rsp_tlast, rsp_tuser[2]}, why))
               report(why);
         end
         if (stall > 0) begin
            rsp_tready <= 0;
            stall <= stall - 1;
         end else begin
            rsp_tready <= 1;
            stall <= pick_gap();
         end
      end
   end

   // watchdog on cycles with no item moving on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [15:0] dir[] = '{16'h2105, 16'h2280, 16'h0048, 16'h088B, 16'h000C, 16'h044D,
                             16'h188E, 16'h3103, 16'h2908, 16'hDD02, 16'h4688, 16'h4B01,
                             16'h5A8F, 16'h6048, 16'h684B, 16'h8048, 16'h884C, 16'h2501,
                             16'h882C, 16'hA903, 16'hB081, 16'hB004, 16'hB401, 16'hF123,
                             16'hE7FE, 16'hE001, 16'h2800, 16'hDDF0};
      board = new();
      board.reset_state();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed forms from the reset start address
      foreach (dir[i]) run_instr(dir[i]);
      write_start(16'h0000);
      random_until(450);
      write_start(16'hFFFE);
      random_until(800);
      // hold the sender until the core has caught up
      drain();
      random_until(1000);
      write_start(16'($urandom) | 16'h0001);
      random_until(1200);
      write_start(16'($urandom));
      random_until(1520);

      // halt, then executes are dropped and loads still land
      run_instr(16'hBD00);
      repeat (5) send_item('{1'b1, 15'($urandom), 16'($urandom)});
      send_load(15'h7FFF, 16'hFFFF);
      drain();
      repeat (30) @(posedge clock);

      $display("ran %0d items: %0d executes, %0d loads, %0d traces checked",
               items_sent, board.execs, board.loads, traces_seen);
      $display("start address settings: reset, 0, top, odd, random; halt covered");
      if (errors == 0 && board.owed.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
